@@ rtl/jetl_pkg.sv @@
// Shared types and constants for the JSON escape token lexer.
// Used by every module of the block; depends on nothing.
package jetl_pkg;

   // Most result beats that one input byte can cause
   localparam int MAX_RESULTS = 4;
   localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);
   localparam int RIDX_W      = $clog2(MAX_RESULTS);
   localparam int QUEUE_DEPTH = 2;

   // Result kinds
   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // Characters of interest
   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_FF        = 8'h0C;
   localparam logic [7:0] CH_BS        = 8'h08;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_U         = 8'h75;

   // String delimiter tokens
   localparam logic [7:0] TOK_OPEN  = 8'h01;
   localparam logic [7:0] TOK_CLOSE = 8'h00;

   localparam logic [2:0] HEX_DIGITS = 3'd4;

   // UTF-8 framing
   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF8_CONT  = 8'h80;
   localparam logic [7:0] UTF8_MASK  = 8'h3F;

   localparam logic [15:0] CP_NONCHAR = 16'hFFFE;
   localparam logic [15:0] CP_BOM     = 16'hFEFF;
   localparam logic [15:0] CP_SUR_LO  = 16'hD800;
   localparam logic [15:0] CP_SUR_HI  = 16'hDFFF;

   typedef logic [RCNT_W-1:0] rcnt_type;
   typedef logic [RIDX_W-1:0] ridx_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] out_kind;
      logic       out_last;
   } rsp_type;

   // All results caused by one input byte
   typedef struct packed {
      rcnt_type                         rslt_cnt;
      logic [MAX_RESULTS-1:0][7:0]      rslt_byte;
      logic [MAX_RESULTS-1:0][1:0]      rslt_kind;
   } bundle_type;

endpackage

@@ rtl/json_escape_token_lexer_unit.sv @@
// Top level of the JSON escape token lexer: front, bundle queue and back.
// Depends on jetl_pkg, jetl_front, jetl_queue and jetl_back.
//
//   channel | direction | handshake            | beat payload
//   --------+-----------+----------------------+-------------------------------
//   req_    | in        | req_valid/req_ready  | in_byte, in_last
//   rsp_    | out       | rsp_valid/rsp_ready  | out_byte, out_kind, out_last
//
// One byte is taken per cycle while the queue has room. A byte that yields k result beats
// (k = 0..4) keeps the back part busy while it emits them; zero-result bytes (whitespace,
// escape heads, hex digits mid-sequence, bytes after an error) never reach the back part.
// A request's bundle is registered in the queue before its beats pass the output register.
// Reset is synchronous: lexer state, queue pointers, output valid and beat index clear.
// When rsp_ready stays low, the output register and the queue fill, then req_ready drops.
module json_escape_token_lexer_unit #(
   parameter int QueueDepth = jetl_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  jetl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output jetl_pkg::rsp_type rsp_data
);

   // Front to queue
   logic                 push_valid, push_ready;
   jetl_pkg::bundle_type push_data;

   // Queue to back
   logic                 head_valid, head_pop;
   jetl_pkg::bundle_type head_data;

   // Classifies each beat and keeps the string / escape / hex state
   jetl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // Lets the front keep taking bytes while the back emits a multi-beat bundle
   jetl_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (head_valid),
      .pop        (head_pop),
      .pop_data   (head_data)
   );

   // Streams one result beat per cycle while rsp_ready allows, marks the last of each bundle
   jetl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

@@ rtl/jetl_front.sv @@
// Front part: lexer state and classification of each input byte into a result bundle.
// Depends on jetl_pkg.
module jetl_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  jetl_pkg::req_type    req_data,
   input  logic                 push_ready,
   output logic                 push_valid,
   output jetl_pkg::bundle_type push_data
);

   logic        in_string_ff, in_string_in;
   logic        escape_ff,    escape_in;
   logic [2:0]  hex_left_ff,  hex_left_in;
   logic [15:0] hex_value_ff, hex_value_in;
   logic        error_ff,     error_in;

   logic accept;

   function automatic logic [4:0] hex_of(input logic [7:0] c);
      // {valid, digit}
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
      return r;
   endfunction

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      logic [7:0]  c;
      logic        msg_end;
      logic [4:0]  hd;
      logic [15:0] cp;
      logic        body_err;
      jetl_pkg::rcnt_type                           body_n;
      logic [jetl_pkg::MAX_RESULTS-1:0][7:0]        body_byte;
      logic [jetl_pkg::MAX_RESULTS-1:0][1:0]        body_kind;
      logic        end_put;
      logic [1:0]  end_kind;

      c        = req_data.in_byte;
      msg_end  = (c == jetl_pkg::CH_NUL) || req_data.in_last;
      hd       = hex_of(c);
      cp       = {hex_value_ff[11:0], hd[3:0]};
      body_err = 1'b0;
      body_n   = '0;
      body_byte = '0;
      body_kind = '0;
      end_put  = 1'b0;
      end_kind = jetl_pkg::KIND_END;

      in_string_in = in_string_ff;
      escape_in    = escape_ff;
      hex_left_in  = hex_left_ff;
      hex_value_in = hex_value_ff;
      error_in     = error_ff;

      if (!error_ff && c != jetl_pkg::CH_NUL) begin
         if (hex_left_ff != 3'd0) begin
            if (!hd[4]) begin
               body_err = 1'b1;
            end else begin
               hex_value_in = cp;
               hex_left_in  = hex_left_ff - 3'd1;
               if (hex_left_ff == 3'd1) begin
                  hex_value_in = '0;
                  if (cp == 16'd0 || cp == jetl_pkg::CP_NONCHAR || cp == jetl_pkg::CP_BOM ||
                      (cp >= jetl_pkg::CP_SUR_LO && cp <= jetl_pkg::CP_SUR_HI)) begin
                     body_err = 1'b1;
                  end else if (cp[15:7] == 9'd0) begin
                     body_n       = jetl_pkg::RCNT_W'(1);
                     body_byte[0] = cp[7:0];
                  end else if (cp[15:11] == 5'd0) begin
                     body_n       = jetl_pkg::RCNT_W'(2);
                     body_byte[0] = jetl_pkg::UTF8_LEAD2 | {3'd0, cp[10:6]};
                     body_byte[1] = jetl_pkg::UTF8_CONT | ({2'd0, cp[5:0]} & jetl_pkg::UTF8_MASK);
                  end else begin
                     body_n       = jetl_pkg::RCNT_W'(3);
                     body_byte[0] = jetl_pkg::UTF8_LEAD3 | {4'd0, cp[15:12]};
                     body_byte[1] = jetl_pkg::UTF8_CONT | ({2'd0, cp[11:6]} & jetl_pkg::UTF8_MASK);
                     body_byte[2] = jetl_pkg::UTF8_CONT | ({2'd0, cp[5:0]} & jetl_pkg::UTF8_MASK);
                  end
               end
            end
         end else if (escape_ff) begin
            escape_in    = 1'b0;
            body_n       = jetl_pkg::RCNT_W'(1);
            body_byte[0] = c;
            unique case (c)
               jetl_pkg::CH_QUOTE, jetl_pkg::CH_BACKSLASH, jetl_pkg::CH_SLASH: ;
               jetl_pkg::CH_B: body_byte[0] = jetl_pkg::CH_BS;
               jetl_pkg::CH_F: body_byte[0] = jetl_pkg::CH_FF;
               jetl_pkg::CH_N: body_byte[0] = jetl_pkg::CH_LF;
               jetl_pkg::CH_R: body_byte[0] = jetl_pkg::CH_CR;
               jetl_pkg::CH_T: body_byte[0] = jetl_pkg::CH_TAB;
               jetl_pkg::CH_U: begin
                  body_n       = '0;
                  hex_left_in  = jetl_pkg::HEX_DIGITS;
                  hex_value_in = '0;
               end
               default: begin
                  body_n   = '0;
                  body_err = 1'b1;
               end
            endcase
         end else if (in_string_ff && c == jetl_pkg::CH_BACKSLASH) begin
            escape_in = 1'b1;
         end else if (c == jetl_pkg::CH_QUOTE) begin
            body_n       = jetl_pkg::RCNT_W'(1);
            body_byte[0] = in_string_ff ? jetl_pkg::TOK_CLOSE : jetl_pkg::TOK_OPEN;
            in_string_in = !in_string_ff;
         end else if (!in_string_ff &&
                      (c == jetl_pkg::CH_SPACE || (c >= jetl_pkg::CH_TAB && c <= jetl_pkg::CH_CR))) begin
            body_n = '0;
         end else begin
            body_n       = jetl_pkg::RCNT_W'(1);
            body_byte[0] = c;
         end

         if (body_err) begin
            body_n       = jetl_pkg::RCNT_W'(1);
            body_byte[0] = 8'd0;
            body_kind[0] = jetl_pkg::KIND_ERR;
            error_in     = 1'b1;
            escape_in    = 1'b0;
            hex_left_in  = '0;
            hex_value_in = '0;
         end
      end

      if (msg_end) begin
         if (!error_ff && !error_in) begin
            end_put  = 1'b1;
            end_kind = (escape_in || hex_left_in != 3'd0) ? jetl_pkg::KIND_ERR
                                                          : jetl_pkg::KIND_END;
         end
         in_string_in = 1'b0;
         escape_in    = 1'b0;
         hex_left_in  = '0;
         hex_value_in = '0;
         error_in     = 1'b0;
      end

      // End beat goes right after the body beats
      for (int i = 0; i < jetl_pkg::MAX_RESULTS; i++) begin
         if (jetl_pkg::RCNT_W'(i) < body_n) begin
            push_data.rslt_byte[i] = body_byte[i];
            push_data.rslt_kind[i] = body_kind[i];
         end else begin
            push_data.rslt_byte[i] = 8'd0;
            push_data.rslt_kind[i] = end_kind;
         end
      end
      push_data.rslt_cnt = body_n + jetl_pkg::RCNT_W'(end_put);
   end

   assign push_valid = accept && (push_data.rslt_cnt != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_string_ff <= 1'b0;
         escape_ff    <= 1'b0;
         hex_left_ff  <= '0;
         hex_value_ff <= '0;
         error_ff     <= 1'b0;
      end else if (accept) begin
         in_string_ff <= in_string_in;
         escape_ff    <= escape_in;
         hex_left_ff  <= hex_left_in;
         hex_value_ff <= hex_value_in;
         error_ff     <= error_in;
      end
   end

`ifndef SYNTHESIS
   // Once an error is latched, no escape may still be in progress
   a_err_clears_escape: assert property (@(posedge clock) disable iff (reset)
      error_ff |-> (!escape_ff && hex_left_ff == 3'd0))
      else $error("escape state left over after error");
`endif

endmodule

@@ rtl/jetl_queue.sv @@
// Short bundle queue that decouples the front and back parts.
// Depends on jetl_pkg.
module jetl_queue #(
   parameter int Depth = jetl_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  jetl_pkg::bundle_type push_data,
   output logic                 pop_valid,
   input  logic                 pop,
   output jetl_pkg::bundle_type pop_data
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   jetl_pkg::bundle_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff,  count_in;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != CntW'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue count above depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow push");
`endif

endmodule

@@ rtl/jetl_back.sv @@
// Back part: unpacks queued bundles into result beats through an output register.
// Depends on jetl_pkg.
module jetl_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  jetl_pkg::bundle_type head_data,
   output logic                 head_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output jetl_pkg::rsp_type    rsp_data
);

   jetl_pkg::ridx_type idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   jetl_pkg::rsp_type  rsp_ff, rsp_in;
   logic               load, is_final;

   assign load     = head_valid && (!rsp_valid_ff || rsp_ready);
   assign is_final = ({1'b0, idx_ff} == (head_data.rslt_cnt - 1'b1));
   assign head_pop = load && is_final;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (load) begin
         rsp_valid_in    = 1'b1;
         rsp_in.out_byte = head_data.rslt_byte[idx_ff];
         rsp_in.out_kind = head_data.rslt_kind[idx_ff];
         rsp_in.out_last = is_final;
         idx_in          = is_final ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_bundle_nonempty: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (head_data.rslt_cnt != '0 &&
                      head_data.rslt_cnt <= jetl_pkg::RCNT_W'(jetl_pkg::MAX_RESULTS) &&
                      {1'b0, idx_ff} < head_data.rslt_cnt))
      else $error("queued bundle count or beat index out of range");
`endif

endmodule

@@ verif/jetl_test_pkg.sv @@
// Scoreboard for the JSON escape token lexer testbench: a byte-level lexer
// predictor plus the queue of result beats it expects. Needs jetl_pkg.
`timescale 1ns / 100ps
package jetl_test_pkg;
   import jetl_pkg::*;

   class token_scoreboard;
      // predictor state, mirrors the lexer's own
      bit          in_string;
      bit          escape_open;
      logic [2:0]  hex_left;
      logic [15:0] hex_acc;
      bit          dropping;

      rsp_type     expected_tokens[$];
      rsp_type     byte_tokens[$];
      int unsigned n_checked;
      int unsigned n_mismatch;
      int unsigned n_end;
      int unsigned n_err;

      // predictor starts from the lexer's reset state
      function new();
         clear_state();
      endfunction

      function void clear_state();
         in_string   = 1'b0;
         escape_open = 1'b0;
         hex_left    = '0;
         hex_acc     = '0;
         dropping    = 1'b0;
      endfunction

      function void put_token(logic [7:0] b, logic [1:0] kind);
         rsp_type t;
         t.out_byte = b;
         t.out_kind = kind;
         t.out_last = 1'b0;
         byte_tokens.push_back(t);
      endfunction

      function void flag_error();
         put_token(8'h00, KIND_ERR);
         dropping    = 1'b1;
         escape_open = 1'b0;
         hex_left    = '0;
         hex_acc     = '0;
      endfunction

      function int hex_nibble(logic [7:0] c);
         if (c >= "0" && c <= "9") return int'(c - "0");
         if (c >= "A" && c <= "F") return int'(c - "A") + 10;
         if (c >= "a" && c <= "f") return int'(c - "a") + 10;
         return -1;
      endfunction

      function void put_code_point(logic [15:0] cp);
         if (cp < 16'h0080) begin
            put_token(cp[7:0], KIND_DATA);
         end else if (cp < 16'h0800) begin
            put_token(UTF8_LEAD2 | {3'b000, cp[10:6]}, KIND_DATA);
            put_token(UTF8_CONT | {2'b00, cp[5:0]}, KIND_DATA);
         end else begin
            put_token(UTF8_LEAD3 | {4'h0, cp[15:12]}, KIND_DATA);
            put_token(UTF8_CONT | {2'b00, cp[11:6]}, KIND_DATA);
            put_token(UTF8_CONT | {2'b00, cp[5:0]}, KIND_DATA);
         end
      endfunction

      function void lex_char(logic [7:0] c);
         int          d;
         logic [15:0] cp;
         logic [7:0]  v;
         if (hex_left != 0) begin
            d = hex_nibble(c);
            if (d < 0) begin
               flag_error();
               return;
            end
            hex_acc  = {hex_acc[11:0], d[3:0]};
            hex_left = hex_left - 3'd1;
            if (hex_left == 0) begin
               cp      = hex_acc;
               hex_acc = '0;
               if (cp == 16'h0000 || cp == CP_NONCHAR || cp == CP_BOM ||
                   (cp >= CP_SUR_LO && cp <= CP_SUR_HI))
                  flag_error();
               else
                  put_code_point(cp);
            end
            return;
         end
         if (escape_open) begin
            escape_open = 1'b0;
            case (c)
               CH_QUOTE, CH_BACKSLASH, CH_SLASH: v = c;
               CH_B: v = CH_BS;
               CH_F: v = CH_FF;
               CH_N: v = CH_LF;
               CH_R: v = CH_CR;
               CH_T: v = CH_TAB;
               CH_U: begin
                  hex_left = HEX_DIGITS;
                  hex_acc  = '0;
                  return;
               end
               default: begin
                  flag_error();
                  return;
               end
            endcase
            put_token(v, KIND_DATA);
            return;
         end
         if (in_string && c == CH_BACKSLASH) begin
            escape_open = 1'b1;
            return;
         end
         if (c == CH_QUOTE) begin
            put_token(in_string ? TOK_CLOSE : TOK_OPEN, KIND_DATA);
            in_string = !in_string;
            return;
         end
         if (!in_string && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) return;
         put_token(c, KIND_DATA);
      endfunction

      // Returns 0 when the byte is swallowed after an escape error.
      function bit note_byte(req_type r);
         bit ends;
         ends = (r.in_byte == CH_NUL) || r.in_last;
         byte_tokens.delete();
         if (dropping) begin
            if (ends) clear_state();
            return 1'b0;
         end
         if (r.in_byte != CH_NUL) lex_char(r.in_byte);
         if (ends) begin
            if (!dropping) begin
               if (escape_open || hex_left != 0)
                  put_token(8'h00, KIND_ERR);
               else
                  put_token(8'h00, KIND_END);
            end
            clear_state();
         end
         if (byte_tokens.size() != 0)
            byte_tokens[byte_tokens.size() - 1].out_last = 1'b1;
         foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
         return 1'b1;
      endfunction

      function void check_token(rsp_type got);
         rsp_type want;
         n_checked++;
         if (got.out_kind == KIND_END) n_end++;
         if (got.out_kind == KIND_ERR) n_err++;
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual byte %h kind %0d last %0b",
                     $time, got.out_byte, got.out_kind, got.out_last);
            n_mismatch++;
            return;
         end
         want = expected_tokens.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %h, actual %h", $time, want.out_byte, got.out_byte);
            n_mismatch++;
         end
         if (got.out_kind !== want.out_kind) begin
            $display("%0t: out_kind expected %0d, actual %0d", $time, want.out_kind, got.out_kind);
            n_mismatch++;
         end
         if (got.out_last !== want.out_last) begin
            $display("%0t: out_last expected %0b, actual %0b", $time, want.out_last, got.out_last);
            n_mismatch++;
         end
      endfunction

      function void report_leftovers();
         foreach (expected_tokens[i]) begin
            $display("%0t: missing result beat, expected byte %h kind %0d last %0b, actual none",
                     $time, expected_tokens[i].out_byte, expected_tokens[i].out_kind,
                     expected_tokens[i].out_last);
            n_mismatch++;
         end
      endfunction
   endclass

endpackage

@@ verif/json_escape_token_lexer_unit_test.sv @@
// Top-level testbench for json_escape_token_lexer_unit: directed and random JSON
// messages, random idling on both channels. Needs jetl_pkg and jetl_test_pkg.
`timescale 1ns / 100ps
module json_escape_token_lexer_unit_test;
   import jetl_pkg::*;
   import jetl_test_pkg::*;

   // random input beats, on top of the directed ones
   localparam int unsigned RANDOM_ITEMS    = 380;
   localparam int unsigned HOLD_OFF_CYCLES = 200;
   localparam int unsigned STALL_LIMIT     = 3000;
   localparam int unsigned DRAIN_CYCLES    = 8;

   localparam logic [7:0] SIMPLE_ESCAPES [8] =
      '{CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

   typedef enum int unsigned {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;
   typedef enum int unsigned {MSG_NOISE, MSG_BROKEN, MSG_CLEAN} msg_style_e;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   token_scoreboard sb = new();

   int unsigned live_items;    // beats the lexer actually acts on
   int unsigned in_beats;
   int unsigned idle_cycles;
   int unsigned n_messages;
   int unsigned burst_left;
   bit          hold_off_req;  // set by stimulus, cleared by the receiver
   logic [7:0]  msg[$];
   bit          msg_by_last;
   msg_style_e  msg_style;

   json_escape_token_lexer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Monitor: both channels sampled at the rising edge. Inputs only move on
   // the falling edge, so what is read here is the pre-edge value.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (req_valid && req_ready) begin
            in_beats++;
            if (sb.note_byte(req_data)) live_items++;
         end
         if (rsp_valid && rsp_ready) sb.check_token(rsp_data);
      end
   end

   // Watchdog: nothing moved on either channel for too long
   initial begin : watchdog
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver: rsp_ready follows a pattern that is drawn anew after each
   // random span. On request it holds off for a long counted stretch so the
   // output register and queue fill and req_ready drops.
   // ---------------------------------------------------------------------
   initial begin : receiver
      rx_mode_e    mode;
      int unsigned span;
      rsp_ready = 1'b0;
      forever begin
         mode = rx_mode_e'($urandom_range(0, 3));
         span = $urandom_range(8, 48);
         for (int k = 0; k < span; k++) begin
            @(negedge clock);
            if (hold_off_req) begin
               rsp_ready <= 1'b0;
               repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
               hold_off_req = 1'b0;
            end else begin
               case (mode)
                  RX_ALWAYS: rsp_ready <= 1'b1;
                  RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
                  RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
                  default:   rsp_ready <= (k % 5 != 4);
               endcase
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender: bursts of back-to-back beats with random gaps; now and then a
   // long burst with no gaps at all. Valid stays up until accepted.
   // ---------------------------------------------------------------------
   task automatic send_beat(input logic [7:0] b, input bit last);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            @(negedge clock) req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= '{in_byte: b, in_last: last};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_text(input string s, input bit last_at_end);
      for (int i = 0; i < s.len(); i++)
         send_beat(s[i], last_at_end && (i == s.len() - 1));
   endtask

   // Sender goes quiet until every outstanding result has come back
   task automatic drain_results();
      @(negedge clock) req_valid <= 1'b0;
      while (sb.expected_tokens.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Message builder
   // ---------------------------------------------------------------------
   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 10) return "0" + 8'(n);
      return (($urandom_range(0, 1) != 0) ? "A" : "a") + 8'(n) - 8'd10;
   endfunction

   task automatic push_unicode(input logic [15:0] cp);
      msg.push_back(CH_BACKSLASH);
      msg.push_back(CH_U);
      for (int i = 3; i >= 0; i--) msg.push_back(hex_char(cp[i*4 +: 4]));
   endtask

   function automatic logic [15:0] good_code_point();
      logic [15:0] cp;
      case ($urandom_range(0, 7))
         0, 1: cp = 16'($urandom_range(1, 16'h007F));
         2, 3: cp = 16'($urandom_range(16'h0080, 16'h07FF));
         4: begin
            case ($urandom_range(0, 8))
               0: cp = 16'h0001;
               1: cp = 16'h007F;
               2: cp = 16'h0080;
               3: cp = 16'h07FF;
               4: cp = 16'h0800;
               5: cp = 16'hD7FF;
               6: cp = 16'hE000;
               7: cp = 16'hFFFD;
               default: cp = 16'hFFFF;
            endcase
         end
         default: begin
            do cp = 16'($urandom_range(16'h0800, 16'hFFFF));
            while (cp == CP_NONCHAR || cp == CP_BOM || (cp >= CP_SUR_LO && cp <= CP_SUR_HI));
         end
      endcase
      return cp;
   endfunction

   // Bytes outside strings: whitespace, structure, bare text, stray backslash
   task automatic push_filler();
      int unsigned n;
      logic [7:0]  c;
      n = $urandom_range(1, 4);
      repeat (n) begin
         case ($urandom_range(0, 4))
            0: begin
               case ($urandom_range(0, 5))
                  0: c = CH_SPACE;
                  1: c = CH_TAB;
                  2: c = CH_LF;
                  3: c = 8'h0B;
                  4: c = CH_FF;
                  default: c = CH_CR;
               endcase
            end
            1: begin
               case ($urandom_range(0, 5))
                  0: c = "{";
                  1: c = "}";
                  2: c = "[";
                  3: c = "]";
                  4: c = ":";
                  default: c = ",";
               endcase
            end
            2: c = CH_BACKSLASH;
            default: do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE);
         endcase
         msg.push_back(c);
      end
   endtask

   // A quoted string; a broken one ends in a bad or unfinished escape
   task automatic push_string(input bit broken);
      int unsigned n;
      logic [7:0]  c;
      msg.push_back(CH_QUOTE);
      n = $urandom_range(0, 6);
      repeat (n) begin
         case ($urandom_range(0, 5))
            0, 1, 2: begin
               do c = 8'($urandom_range(1, 255));
               while (c == CH_QUOTE || c == CH_BACKSLASH);
               msg.push_back(c);
            end
            3: begin
               msg.push_back(CH_BACKSLASH);
               msg.push_back(SIMPLE_ESCAPES[$urandom_range(0, 7)]);
            end
            default: push_unicode(good_code_point());
         endcase
      end
      if (broken) begin
         case ($urandom_range(0, 4))
            0: begin  // unknown escape letter
               do c = 8'($urandom_range(0, 255));
               while (c inside {CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_B, CH_F, CH_N,
                                CH_R, CH_T, CH_U});
               msg.push_back(CH_BACKSLASH);
               msg.push_back(c);
            end
            1: begin  // non-hex digit partway through \u
               msg.push_back(CH_BACKSLASH);
               msg.push_back(CH_U);
               repeat ($urandom_range(0, 3)) msg.push_back(hex_char(4'($urandom_range(0, 15))));
               do c = 8'($urandom_range(0, 255));
               while (c inside {["0":"9"], ["A":"F"], ["a":"f"]});
               msg.push_back(c);
            end
            2: begin  // code point that must be refused
               case ($urandom_range(0, 3))
                  0: push_unicode(16'h0000);
                  1: push_unicode(CP_NONCHAR);
                  2: push_unicode(CP_BOM);
                  default: push_unicode(16'($urandom_range(CP_SUR_LO, CP_SUR_HI)));
               endcase
            end
            3: begin  // message stops right after the backslash
               msg.push_back(CH_BACKSLASH);
               return;
            end
            default: begin  // message stops inside the hex digits
               msg.push_back(CH_BACKSLASH);
               msg.push_back(CH_U);
               repeat ($urandom_range(0, 3)) msg.push_back(hex_char(4'($urandom_range(0, 15))));
               return;
            end
         endcase
      end
      msg.push_back(CH_QUOTE);
   endtask

   task automatic build_message();
      int unsigned r;
      int unsigned parts;
      msg.delete();
      r = $urandom_range(0, 9);
      msg_style = (r == 0) ? MSG_NOISE : (r < 3) ? MSG_BROKEN : MSG_CLEAN;
      if (msg_style == MSG_NOISE) begin
         repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom_range(0, 255)));
      end else begin
         parts = $urandom_range(1, 4);
         for (int i = 0; i < parts; i++) begin
            if ($urandom_range(0, 2) == 0)
               push_filler();
            else
               push_string(msg_style == MSG_BROKEN && i == parts - 1);
         end
         // a broken message that ends in a quote gets one more broken string at random
         if (msg_style == MSG_BROKEN && msg[msg.size() - 1] == CH_QUOTE && parts > 0 &&
             $urandom_range(0, 1) == 0)
            push_string(1'b1);
      end
      msg_by_last = $urandom_range(0, 1);
   endtask

   task automatic send_message();
      bit last;
      for (int i = 0; i < msg.size(); i++) begin
         last = (msg_by_last && i == msg.size() - 1) ||
                (msg_style == MSG_NOISE && $urandom_range(0, 7) == 0);
         send_beat(msg[i], last);
      end
      if (!msg_by_last) send_beat(CH_NUL, $urandom_range(0, 3) == 0);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int unsigned base;
      bit          hold_done;
      bit          paused;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      hold_done = 1'b0;
      paused    = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Backslash passes through outside a string, whitespace there is dropped;
      // then a newline escape, a two-byte code point with mixed-case digits and
      // an unknown escape letter. Bytes after the error, 0xFF among them, are
      // dropped and the terminating zero gives nothing.
      send_beat(CH_BACKSLASH, 1'b0);
      send_beat(CH_SPACE, 1'b0);
      send_text("\"\\n\\u07Ff\\q", 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(CH_NUL, 1'b0);
      // surrogate refused on the buffer's last byte: error only, no end beat
      send_text("\"\\uD800", 1'b1);
      // buffer ends right after a backslash
      send_text("\"\\", 1'b1);
      // zero byte while an escape is open
      send_text("\"\\", 1'b0);
      send_beat(CH_NUL, 1'b1);
      // non-hex character in \u
      send_text("\"\\uG", 1'b0);
      send_beat(CH_NUL, 1'b0);
      // fourth hex digit on the last byte: three UTF-8 bytes, then the end beat
      send_text("\"\\uFFFd", 1'b1);
      drain_results();

      base = in_beats;
      while (in_beats - base < RANDOM_ITEMS) begin
         build_message();
         send_message();
         n_messages++;
         if (!hold_done && in_beats - base > 120) begin
            hold_off_req = 1'b1;
            hold_done    = 1'b1;
         end
         if (!paused && in_beats - base > 260) begin
            drain_results();
            paused = 1'b1;
         end
      end

      @(negedge clock) req_valid <= 1'b0;
      while (sb.expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.report_leftovers();

      $display("Run covered %0d random messages plus directed escapes: %0d input beats, %0d lexed.",
               n_messages, in_beats, live_items);
      $display("Checked %0d result beats, %0d message ends, %0d escape errors, %0d mismatches.",
               sb.n_checked, sb.n_end, sb.n_err, sb.n_mismatch);
      if (sb.n_mismatch == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
